@@ rtl/core/pidspd_pkg.sv @@
// Package for the PID speed loop: payload structs, widths, constants,
// controller states and multiplier control types. No dependencies.
package pidspd_pkg;

  localparam int GAIN_W     = 16;
  localparam int MC_W       = 33;
  localparam int ACC_W      = 52;
  localparam int FF_ENTRIES = 128;

  localparam logic signed [15:0] FF_SEED_LIMIT = 16'sd33;
  localparam logic signed [16:0] FF_SEED_STEP  = 17'sd655;
  localparam logic signed [15:0] FF_SAT_LIMIT  = 16'sd32440;
  localparam logic signed [15:0] FF_FULL       = 16'sd32767;
  localparam logic signed [16:0] FF_NUDGE      = 17'sd164;
  localparam logic signed [8:0]  JUMP_LIMIT    = 9'sd5;

  localparam logic [2:0] REG_PROP    = 3'd0;
  localparam logic [2:0] REG_INTEG   = 3'd1;
  localparam logic [2:0] REG_DERIV   = 3'd2;
  localparam logic [2:0] REG_REVERSE = 3'd3;
  localparam logic [2:0] REG_DUTYTOP = 3'd4;
  localparam logic [2:0] REG_UPPER   = 3'd5;
  localparam logic [2:0] REG_LOWER   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_CALIB = 2'd2;

  typedef enum logic [1:0] {
    PH_P,
    PH_I,
    PH_D,
    PH_DUTY
  } mul_phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_C0,
    S_C1,
    S_MUL,
    S_MNXT,
    S_SAT,
    S_DRV,
    S_K0,
    S_K1,
    S_K2,
    S_K3,
    S_K4,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mul_ctl_t;

  typedef struct packed {
    logic              opcode;
    logic [15:0]       encoder_count;
    logic signed [7:0] target_speed;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        duty_fwd;
    logic [15:0]        duty_rev;
    logic               duty_written;
    logic signed [15:0] command;
    logic signed [15:0] speed;
    logic [1:0]         status;
    logic               calib_done;
  } out_item_t;

endpackage

@@ rtl/core/pidspd_mul.sv @@
// Bit-serial shift-and-add multiply-accumulate, one gain bit per cycle.
// Depends on pidspd_pkg for widths and the control struct.
module pidspd_mul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pidspd_pkg::mul_ctl_t                   ctl,
  input  logic signed [pidspd_pkg::MC_W-1:0]     mcand,
  input  logic [pidspd_pkg::GAIN_W-1:0]          mult,
  output logic signed [pidspd_pkg::ACC_W-1:0]    acc,
  output logic                                   done
);

  localparam int CNT_W = $clog2(pidspd_pkg::GAIN_W);

  logic                                busy;
  logic [CNT_W-1:0]                    cnt;
  logic signed [pidspd_pkg::ACC_W-1:0] mc;
  logic [pidspd_pkg::GAIN_W-1:0]       mr;

  assign done = busy && (cnt == CNT_W'(pidspd_pkg::GAIN_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mc <= pidspd_pkg::ACC_W'(mcand);
      mr <= mult;
      if (ctl.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (mr[0]) begin
        acc <= acc + mc;
      end
      mc <= mc <<< 1;
      mr <= mr >> 1;
    end
  end

endmodule

@@ rtl/core/pid_speed_loop_with_feedforward_unit.sv @@
// PID motor speed loop with a learned feedforward table, Q1.15 fixed point.
// One transaction at a time: in_stall is high outside the idle state and drops in the same
// cycle that out_valid rises, so the next transaction can be taken while the result is held.
// A zero target skips the products, and a command that fails the limits skips the duty one.
// Synchronous reset clears the configuration, loop and control state and the table valid bits;
// the datapath registers and the table entries are not reset.
module pid_speed_loop_with_feedforward_unit #(
  parameter int FF_ENTRIES = pidspd_pkg::FF_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pidspd_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pidspd_pkg::out_item_t out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int AW = $clog2(FF_ENTRIES);
  localparam logic [8:0] FF_N = 9'(FF_ENTRIES);

  // Configuration registers.
  logic [15:0]        prop_gain, integ_gain, deriv_gain, duty_top;
  logic               reverse_dir;
  logic [14:0]        cmd_upper;
  logic signed [15:0] cmd_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      reverse_dir <= 1'b0;
      duty_top    <= 16'd1000;
      cmd_upper   <= 15'd32767;
      cmd_lower   <= -16'sd32768;
    end else if (cfg_we) begin
      case (cfg_index)
        pidspd_pkg::REG_PROP:    prop_gain   <= cfg_data;
        pidspd_pkg::REG_INTEG:   integ_gain  <= cfg_data;
        pidspd_pkg::REG_DERIV:   deriv_gain  <= cfg_data;
        pidspd_pkg::REG_REVERSE: reverse_dir <= cfg_data[0];
        pidspd_pkg::REG_DUTYTOP: duty_top    <= cfg_data;
        pidspd_pkg::REG_UPPER:   cmd_upper   <= cfg_data[14:0];
        pidspd_pkg::REG_LOWER:   cmd_lower   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Loop state carried from one transaction to the next.
  logic [15:0]        prev_count;
  logic signed [15:0] prev_speed;
  logic signed [17:0] prev_error;
  logic signed [31:0] error_sum;
  logic signed [7:0]  prev_target;

  // Per-transaction working registers.
  pidspd_pkg::state_t     state, state_next;
  pidspd_pkg::mul_phase_t phase, sel;
  logic signed [7:0]  tgt;
  logic signed [15:0] spd, old_spd;
  logic signed [17:0] err_r;
  logic signed [18:0] derr_r;
  logic signed [16:0] ff_r;
  logic signed [15:0] e_r, p_r;
  logic signed [15:0] cmd_r;
  logic               neg_r;
  logic [15:0]        r_fwd, r_rev;
  logic               r_wr, r_done;
  logic [1:0]         r_status;

  // Feedforward table with one valid bit per entry; an unwritten entry reads 0.
  logic signed [15:0] mem [FF_ENTRIES];
  logic [FF_ENTRIES-1:0] vld;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic signed [15:0] rd_data;
  logic               rd_vld;
  logic signed [15:0] tbl;
  logic               wr_en;
  logic [AW-1:0]      t_addr;

  assign tbl    = rd_vld ? rd_data : 16'sd0;
  assign t_addr = tgt[AW-1:0];

  // Serial multiplier.
  pidspd_pkg::mul_ctl_t               mul_ctl;
  logic signed [pidspd_pkg::MC_W-1:0] mcand;
  logic [15:0]                        mult;
  logic signed [pidspd_pkg::ACC_W-1:0] mul_acc;
  logic                               mul_done;

  pidspd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mul_ctl),
    .mcand (mcand),
    .mult  (mult),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  // Measurement and control-tick arithmetic.
  logic [15:0]        diff;
  logic signed [8:0]  jump;
  logic               jump_big;
  logic signed [17:0] err_c;
  logic signed [32:0] sum_c;
  logic signed [31:0] sum_sat;
  logic [7:0]         idx;
  logic               idx_ok, cal_ok, need_seed;

  assign diff     = in_data.encoder_count - prev_count;
  assign jump     = 9'(tgt) - 9'(prev_target);
  assign jump_big = (jump > pidspd_pkg::JUMP_LIMIT) || (jump < -pidspd_pkg::JUMP_LIMIT);
  assign err_c    = 18'(tgt) - 18'(spd);
  assign sum_c    = (jump_big ? 33'sd0 : 33'(error_sum)) + 33'(err_c);
  assign sum_sat  = (sum_c > 33'sd2147483647) ? 32'sh7FFFFFFF :
                    (sum_c < -33'sd2147483648) ? 32'sh80000000 : sum_c[31:0];
  assign idx      = tgt[7] ? 8'(-9'(tgt)) : 8'(tgt);
  assign idx_ok   = {1'b0, idx} < FF_N;
  assign cal_ok   = !tgt[7] && ({1'b0, tgt} < FF_N);
  assign need_seed = (tbl < pidspd_pkg::FF_SEED_LIMIT) && (tgt != 8'sd0);

  // Seed from the neighbor entry, never below entry zero.
  logic signed [16:0] seed_ref;
  logic signed [15:0] seed_e;
  assign seed_ref = 17'(p_r) - pidspd_pkg::FF_SEED_STEP;
  assign seed_e   = (seed_ref < 17'(tbl)) ? tbl : seed_ref[15:0];

  // Calibration decision.
  logic signed [15:0] t16;
  logic signed [16:0] e_inc, e_dec;
  logic signed [15:0] e_new, cal_cmd;
  logic               cal_done, cal_issue;

  assign t16   = 16'(tgt);
  assign e_inc = 17'(e_r) + pidspd_pkg::FF_NUDGE;
  assign e_dec = 17'(e_r) - pidspd_pkg::FF_NUDGE;

  always_comb begin
    e_new     = e_r;
    cal_cmd   = e_r;
    cal_done  = 1'b0;
    cal_issue = 1'b1;
    if (e_r > pidspd_pkg::FF_SAT_LIMIT) begin
      e_new     = pidspd_pkg::FF_FULL;
      cal_cmd   = 16'sd0;
      cal_done  = 1'b1;
      cal_issue = 1'b0;
    end else if (spd <= t16 && old_spd < t16) begin
      e_new   = (e_inc > 17'(pidspd_pkg::FF_FULL)) ? pidspd_pkg::FF_FULL : e_inc[15:0];
      cal_cmd = e_new;
    end else if (spd >= t16 && old_spd > t16) begin
      e_new   = (e_dec < -17'sd32768) ? -16'sd32768 : e_dec[15:0];
      cal_cmd = e_new;
    end else if (spd == t16 && old_spd == t16) begin
      cal_cmd  = 16'sd0;
      cal_done = 1'b1;
    end
  end

  // Final PID sum: gains times terms plus feedforward, floor by 256, saturate.
  logic signed [pidspd_pkg::ACC_W-1:0] acc_all, acc_sh;
  logic signed [15:0]                  pid_cmd;
  assign acc_all = mul_acc + (pidspd_pkg::ACC_W'(ff_r) <<< 8);
  assign acc_sh  = acc_all >>> 8;
  assign pid_cmd = (acc_sh > pidspd_pkg::ACC_W'(32767)) ? 16'sh7FFF :
                   (acc_sh < -pidspd_pkg::ACC_W'(32768)) ? 16'sh8000 : acc_sh[15:0];

  // Drive stage: limits, direction and the magnitude guard.
  logic               lim_bad;
  logic signed [16:0] c17;
  logic [16:0]        mag;
  logic signed [17:0] over;
  logic [25:0]        over_k;
  logic               guard_err;

  assign lim_bad   = (17'(cmd_r) > 17'(signed'({1'b0, cmd_upper}))) ||
                     (cmd_r < cmd_lower);
  assign c17       = reverse_dir ? -17'(cmd_r) : 17'(cmd_r);
  assign mag       = c17[16] ? 17'(-c17) : 17'(c17);
  assign over      = signed'(18'(mag)) - signed'(18'(cmd_upper));
  assign over_k    = 26'(over[16:0]) * 26'd1000;
  assign guard_err = (over > 18'sd0) && (over_k > 26'(cmd_upper));

  // Multiplier operand selection per phase.
  always_comb begin
    case (sel)
      pidspd_pkg::PH_P: begin
        mcand = pidspd_pkg::MC_W'(err_r);
        mult  = prop_gain;
      end
      pidspd_pkg::PH_I: begin
        mcand = pidspd_pkg::MC_W'(error_sum);
        mult  = integ_gain;
      end
      pidspd_pkg::PH_D: begin
        mcand = -pidspd_pkg::MC_W'(derr_r);
        mult  = deriv_gain;
      end
      default: begin
        mcand = signed'(pidspd_pkg::MC_W'(mag));
        mult  = duty_top;
      end
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pidspd_pkg::S_IDLE: if (in_valid) begin
        state_next = in_data.opcode ? pidspd_pkg::S_K0 : pidspd_pkg::S_C0;
      end
      pidspd_pkg::S_C0: state_next = pidspd_pkg::S_C1;
      pidspd_pkg::S_C1: begin
        state_next = (tgt == 8'sd0) ? pidspd_pkg::S_DRV : pidspd_pkg::S_MUL;
      end
      pidspd_pkg::S_MUL: if (mul_done) begin
        state_next = pidspd_pkg::S_MNXT;
      end
      pidspd_pkg::S_MNXT: begin
        if (phase == pidspd_pkg::PH_DUTY) begin
          state_next = pidspd_pkg::S_OUT;
        end else if (phase == pidspd_pkg::PH_D) begin
          state_next = pidspd_pkg::S_SAT;
        end else begin
          state_next = pidspd_pkg::S_MUL;
        end
      end
      pidspd_pkg::S_SAT: state_next = pidspd_pkg::S_DRV;
      pidspd_pkg::S_DRV: begin
        state_next = (lim_bad || guard_err) ? pidspd_pkg::S_OUT : pidspd_pkg::S_MUL;
      end
      pidspd_pkg::S_K0: state_next = cal_ok ? pidspd_pkg::S_K1 : pidspd_pkg::S_OUT;
      pidspd_pkg::S_K1: state_next = need_seed ? pidspd_pkg::S_K2 : pidspd_pkg::S_K4;
      pidspd_pkg::S_K2: state_next = pidspd_pkg::S_K3;
      pidspd_pkg::S_K3: state_next = pidspd_pkg::S_K4;
      pidspd_pkg::S_K4: state_next = cal_issue ? pidspd_pkg::S_DRV : pidspd_pkg::S_OUT;
      pidspd_pkg::S_OUT: if (out_free) begin
        state_next = pidspd_pkg::S_IDLE;
      end
      default: state_next = pidspd_pkg::S_IDLE;
    endcase
  end

  // Controller outputs: handshake, table port and multiplier launch.
  always_comb begin
    in_stall      = (state != pidspd_pkg::S_IDLE);
    rd_en         = 1'b0;
    rd_addr       = t_addr;
    wr_en         = 1'b0;
    mul_ctl.start = 1'b0;
    mul_ctl.clear = 1'b0;
    sel           = pidspd_pkg::PH_P;
    case (state)
      pidspd_pkg::S_C0: begin
        rd_en   = idx_ok;
        rd_addr = idx[AW-1:0];
      end
      pidspd_pkg::S_C1: begin
        mul_ctl.start = (tgt != 8'sd0);
        mul_ctl.clear = 1'b1;
      end
      pidspd_pkg::S_MNXT: begin
        sel           = pidspd_pkg::mul_phase_t'(phase + 2'd1);
        mul_ctl.start = (phase == pidspd_pkg::PH_P) || (phase == pidspd_pkg::PH_I);
      end
      pidspd_pkg::S_DRV: begin
        sel           = pidspd_pkg::PH_DUTY;
        mul_ctl.start = !(lim_bad || guard_err);
        mul_ctl.clear = 1'b1;
      end
      pidspd_pkg::S_K0: rd_en = cal_ok;
      pidspd_pkg::S_K1: begin
        rd_en   = need_seed;
        rd_addr = t_addr - 1'b1;
      end
      pidspd_pkg::S_K2: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      pidspd_pkg::S_K4: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[t_addr] <= e_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
      if (wr_en) begin
        vld[t_addr] <= 1'b1;
      end
    end
  end

  // Control state and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pidspd_pkg::S_IDLE;
      phase       <= pidspd_pkg::PH_P;
      prev_count  <= '0;
      prev_speed  <= '0;
      prev_error  <= '0;
      error_sum   <= '0;
      prev_target <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_ctl.start) begin
        phase <= sel;
      end
      if (state == pidspd_pkg::S_IDLE && in_valid) begin
        prev_count <= in_data.encoder_count;
        prev_speed <= signed'(diff);
      end
      if (state == pidspd_pkg::S_C0) begin
        prev_target <= tgt;
        error_sum   <= sum_sat;
        prev_error  <= err_c;
      end
      if (state == pidspd_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction datapath.
  always_ff @(posedge clk) begin
    case (state)
      pidspd_pkg::S_IDLE: if (in_valid) begin
        tgt      <= in_data.target_speed;
        spd      <= signed'(diff);
        old_spd  <= prev_speed;
        cmd_r    <= '0;
        r_fwd    <= '0;
        r_rev    <= '0;
        r_wr     <= 1'b0;
        r_done   <= 1'b0;
        r_status <= pidspd_pkg::ST_OK;
      end
      pidspd_pkg::S_C0: begin
        err_r  <= err_c;
        derr_r <= 19'(err_c) - 19'(prev_error);
      end
      pidspd_pkg::S_C1: begin
        if (!idx_ok) begin
          ff_r <= '0;
        end else begin
          ff_r <= tgt[7] ? -17'(tbl) : 17'(tbl);
        end
      end
      pidspd_pkg::S_SAT: cmd_r <= pid_cmd;
      pidspd_pkg::S_DRV: begin
        neg_r <= c17[16];
        if (lim_bad) begin
          r_status <= pidspd_pkg::ST_LIMIT;
        end else if (guard_err) begin
          r_wr     <= 1'b1;
          r_status <= pidspd_pkg::ST_LIMIT;
        end
      end
      pidspd_pkg::S_MNXT: if (phase == pidspd_pkg::PH_DUTY) begin
        r_wr <= 1'b1;
        if (neg_r) begin
          r_rev <= mul_acc[30:15];
        end else begin
          r_fwd <= mul_acc[30:15];
        end
      end
      pidspd_pkg::S_K0: if (!cal_ok) begin
        r_status <= pidspd_pkg::ST_CALIB;
      end
      pidspd_pkg::S_K1: e_r <= tbl;
      pidspd_pkg::S_K2: p_r <= tbl;
      pidspd_pkg::S_K3: e_r <= seed_e;
      pidspd_pkg::S_K4: begin
        cmd_r  <= cal_cmd;
        r_done <= cal_done;
      end
      pidspd_pkg::S_OUT: if (out_free) begin
        out_data.duty_fwd     <= r_fwd;
        out_data.duty_rev     <= r_rev;
        out_data.duty_written <= r_wr;
        out_data.command      <= cmd_r;
        out_data.speed        <= spd;
        out_data.status       <= r_status;
        out_data.calib_done   <= r_done;
      end
      default: ;
    endcase
  end

endmodule

@@ bench/pid_speed_loop_with_feedforward_unit_test.sv @@
// Self-checking bench for the PID speed loop with feedforward table.
// Depends on pidspd_pkg and pid_speed_loop_with_feedforward_unit only.
`timescale 1ns / 100ps

module pid_speed_loop_with_feedforward_unit_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  pidspd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pidspd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #4 clk = ~clk;

  pid_speed_loop_with_feedforward_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the loop's registers and state.
  logic [15:0] kp, ki, kd, duty_top_r;
  logic rev_dir;
  int cmd_hi, cmd_lo;
  logic [15:0] last_count;
  int last_speed, last_err, integ, last_target;
  int ff_table [pidspd_pkg::FF_ENTRIES];

  pidspd_pkg::in_item_t tick_queue[$];
  pidspd_pkg::out_item_t duty_expect[$];
  int n_errors = 0;
  int n_results = 0;
  int n_control = 0;
  int n_calib = 0;
  int cycles = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  logic [15:0] last_planned = '0;
  int done_base = 0;

  function automatic int pwm_value(int mag, ref bit bad);
    longint prod;
    if (longint'(mag) * 1000 > longint'(cmd_hi) * 1001 || mag < 0) begin
      bad = 1'b1;
      return 0;
    end
    prod = (longint'(mag) * longint'(duty_top_r)) >>> 15;
    return int'(prod & 64'hFFFF);
  endfunction

  // Turn a command into the bridge compare values, honoring the limits.
  function automatic void drive_bridge(int cmd, ref pidspd_pkg::out_item_t r);
    bit bad;
    int c;
    bad = 1'b0;
    if (cmd > cmd_hi || cmd < cmd_lo) begin
      r.status = pidspd_pkg::ST_LIMIT;
      return;
    end
    c = rev_dir ? -cmd : cmd;
    if (c >= 0) begin
      r.duty_rev = 16'(pwm_value(0, bad));
      r.duty_fwd = 16'(pwm_value(c, bad));
    end else begin
      r.duty_fwd = 16'(pwm_value(0, bad));
      r.duty_rev = 16'(pwm_value(-c, bad));
    end
    r.duty_written = 1'b1;
    r.status = bad ? pidspd_pkg::ST_LIMIT : pidspd_pkg::ST_OK;
  endfunction

  function automatic pidspd_pkg::out_item_t predict_tick(pidspd_pkg::in_item_t t);
    pidspd_pkg::out_item_t r;
    int target, prior_speed, spd, cmd, jump, err, derr, ff, idx, e;
    logic [15:0] diff;
    longint acc, s;
    bit issue;
    r = '0;
    target = int'(t.target_speed);
    prior_speed = last_speed;
    diff = t.encoder_count - last_count;
    spd = int'($signed(diff));
    last_count = t.encoder_count;
    last_speed = spd;
    cmd = 0;
    if (t.opcode == 1'b0) begin
      jump = target - last_target;
      if (jump > 5 || jump < -5) integ = 0;
      last_target = target;
      err = target - spd;
      s = longint'(integ) + err;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      integ = int'(s);
      derr = err - last_err;
      last_err = err;
      idx = target < 0 ? -target : target;
      ff = idx < pidspd_pkg::FF_ENTRIES ? ff_table[idx] : 0;
      if (target < 0) ff = -ff;
      if (target != 0) begin
        acc = longint'(kp) * err + longint'(ki) * integ - longint'(kd) * derr
          + longint'(ff) * 256;
        acc = acc >>> 8;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        cmd = int'(acc);
      end
      drive_bridge(cmd, r);
    end else if (target < 0 || target >= pidspd_pkg::FF_ENTRIES) begin
      r.status = pidspd_pkg::ST_CALIB;
    end else begin
      e = ff_table[target];
      issue = 1'b1;
      if (e < 33 && target >= 1) begin
        e = ff_table[target - 1] - 655;
        if (e < ff_table[0]) e = ff_table[0];
      end
      if (e > 32440) begin
        e = 32767;
        r.calib_done = 1'b1;
        issue = 1'b0;
      end else if (spd <= target && prior_speed < target) begin
        e += 164;
        if (e > 32767) e = 32767;
        cmd = e;
      end else if (spd >= target && prior_speed > target) begin
        e -= 164;
        if (e < -32768) e = -32768;
        cmd = e;
      end else if (spd == target && prior_speed == target) begin
        cmd = 0;
        r.calib_done = 1'b1;
      end else begin
        cmd = e;
      end
      ff_table[target] = e;
      if (issue) drive_bridge(cmd, r);
    end
    r.command = cmd[15:0];
    r.speed = spd[15:0];
    return r;
  endfunction

  // Cycle counter and timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Driver: offers queued ticks with random gaps; a payload holds while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_data <= tick_queue[0];
          duty_expect.push_back(predict_tick(tick_queue.pop_front()));
          in_valid <= 1'b1;
          if ($urandom_range(0, 3) == 0)
            gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                    : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    pidspd_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (duty_expect.size() == 0) begin
          $error("result transaction with nothing expected");
          n_errors++;
        end else begin
          want = duty_expect.pop_front();
          if (out_data.duty_fwd !== want.duty_fwd) begin
            $error("duty_fwd exp %0d got %0d", want.duty_fwd, out_data.duty_fwd);
            n_errors++;
          end
          if (out_data.duty_rev !== want.duty_rev) begin
            $error("duty_rev exp %0d got %0d", want.duty_rev, out_data.duty_rev);
            n_errors++;
          end
          if (out_data.duty_written !== want.duty_written) begin
            $error("duty_written exp %0d got %0d", want.duty_written,
                   out_data.duty_written);
            n_errors++;
          end
          if (out_data.command !== want.command) begin
            $error("command exp %0d got %0d", want.command, out_data.command);
            n_errors++;
          end
          if (out_data.speed !== want.speed) begin
            $error("speed exp %0d got %0d", want.speed, out_data.speed);
            n_errors++;
          end
          if (out_data.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_data.status);
            n_errors++;
          end
          if (out_data.calib_done !== want.calib_done) begin
            $error("calib_done exp %0d got %0d", want.calib_done,
                   out_data.calib_done);
            n_errors++;
          end
        end
      end
    end
  end

  // Receiver stall: mostly short random holds, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req <= 1'b0;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left <= ($urandom_range(0, 14) == 0) ? $urandom_range(20, 150)
                                                : $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pidspd_pkg::REG_PROP:    kp = val;
      pidspd_pkg::REG_INTEG:   ki = val;
      pidspd_pkg::REG_DERIV:   kd = val;
      pidspd_pkg::REG_REVERSE: rev_dir = val[0];
      pidspd_pkg::REG_DUTYTOP: duty_top_r = val;
      pidspd_pkg::REG_UPPER:   cmd_hi = int'(val[14:0]);
      pidspd_pkg::REG_LOWER:   cmd_lo = int'($signed(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued tick is out and answered, then let the block settle.
  task automatic wait_idle();
    while (tick_queue.size() > 0 || duty_expect.size() > 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_tick(input logic op, input logic [15:0] cnt,
                          input logic signed [7:0] tgt);
    pidspd_pkg::in_item_t t;
    t.opcode = op;
    t.encoder_count = cnt;
    t.target_speed = tgt;
    tick_queue.push_back(t);
    if (op) n_calib++;
    else n_control++;
  endtask

  // A run of calibration ticks on one target whose speed hovers around it.
  task automatic add_calib_run(input int tgt, input int len);
    logic [15:0] cnt;
    int sp;
    cnt = last_planned;
    for (int k = 0; k < len; k++) begin
      sp = tgt + $signed($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 3) == 0) sp = tgt;
      cnt = cnt + sp[15:0];
      add_tick(1'b1, cnt, tgt[7:0]);
    end
    last_planned = cnt;
  endtask

  task automatic add_control_run(input int len);
    int tgt, sp;
    tgt = $signed($urandom_range(0, 254)) - 127;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 5) == 0) tgt = $signed($urandom_range(0, 254)) - 127;
      else if ($urandom_range(0, 2) == 0) tgt += $signed($urandom_range(0, 12)) - 6;
      if (tgt > 127) tgt = 127;
      if (tgt < -127) tgt = -127;
      sp = tgt + $signed($urandom_range(0, 20)) - 10;
      if ($urandom_range(0, 19) == 0) last_planned = 16'($urandom());
      else last_planned = last_planned + sp[15:0];
      add_tick(1'b0, last_planned, tgt[7:0]);
    end
  endtask

  task automatic random_phase(input int n);
    int done_n;
    done_n = 0;
    while (done_n < n) begin
      case ($urandom_range(0, 4))
        0: begin
          add_calib_run($urandom_range(0, 127), $urandom_range(4, 16));
        end
        1: begin
          // Noise: any opcode, count and target, bad calibration targets too.
          last_planned = 16'($urandom());
          add_tick(1'($urandom()), last_planned, 8'($urandom()));
        end
        default: add_control_run($urandom_range(5, 25));
      endcase
      done_n = n_control + n_calib - done_base;
    end
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0; rev_dir = 1'b0; duty_top_r = 16'd1000;
    cmd_hi = 32767; cmd_lo = -32768;
    last_count = '0; last_speed = 0; last_err = 0; integ = 0; last_target = 0;
    foreach (ff_table[i]) ff_table[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, zero target, extremes, calibration cases.
    add_tick(1'b0, 16'd0, 8'sd0);
    add_tick(1'b0, 16'hFFFF, 8'sd127);
    add_tick(1'b0, 16'h8000, -8'sd127);
    add_tick(1'b1, 16'h8005, -8'sd1);
    add_tick(1'b1, 16'h800A, 8'sd10);
    add_tick(1'b1, 16'h8014, 8'sd10);
    add_tick(1'b1, 16'h801E, 8'sd10);
    add_tick(1'b1, 16'h8030, 8'sd10);
    add_tick(1'b1, 16'h8031, 8'sd0);
    add_tick(1'b0, 16'h803B, 8'sd10);
    add_tick(1'b0, 16'h8045, -8'sd10);
    add_tick(1'b0, 16'h7FFF, 8'sd3);
    wait_idle();

    write_reg(pidspd_pkg::REG_PROP, 16'hFFFF);
    write_reg(pidspd_pkg::REG_INTEG, 16'hFFFF);
    write_reg(pidspd_pkg::REG_DERIV, 16'hFFFF);
    write_reg(pidspd_pkg::REG_DUTYTOP, 16'hFFFF);
    write_reg(pidspd_pkg::REG_UPPER, 16'h7FFF);
    write_reg(pidspd_pkg::REG_LOWER, 16'h8000);
    write_reg(pidspd_pkg::REG_REVERSE, 16'd1);
    add_tick(1'b0, 16'h0000, 8'sd127);
    add_tick(1'b0, 16'h0100, -8'sd127);
    add_tick(1'b0, 16'h0105, -8'sd124);
    add_tick(1'b0, 16'h0090, 8'sd1);
    wait_idle();

    // Narrow limits so the range check and magnitude guard fire.
    write_reg(pidspd_pkg::REG_PROP, 16'd300);
    write_reg(pidspd_pkg::REG_INTEG, 16'd4);
    write_reg(pidspd_pkg::REG_DERIV, 16'd50);
    write_reg(pidspd_pkg::REG_UPPER, 16'd1000);
    write_reg(pidspd_pkg::REG_LOWER, 16'hFC18);
    write_reg(pidspd_pkg::REG_REVERSE, 16'd0);
    write_reg(pidspd_pkg::REG_DUTYTOP, 16'd1);
    last_planned = 16'h0090;
    done_base = n_control + n_calib;
    random_phase(450);
    long_hold_req = 1'b1;
    wait_idle();

    write_reg(pidspd_pkg::REG_PROP, 16'($urandom_range(0, 2000)));
    write_reg(pidspd_pkg::REG_INTEG, 16'($urandom_range(0, 100)));
    write_reg(pidspd_pkg::REG_DERIV, 16'($urandom_range(0, 2000)));
    write_reg(pidspd_pkg::REG_UPPER, 16'd0);
    write_reg(pidspd_pkg::REG_LOWER, 16'd0);
    write_reg(pidspd_pkg::REG_DUTYTOP, 16'd1000);
    write_reg(pidspd_pkg::REG_REVERSE, 16'd1);
    done_base = n_control + n_calib;
    random_phase(300);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(pidspd_pkg::REG_PROP, 16'($urandom()));
      write_reg(pidspd_pkg::REG_INTEG, 16'($urandom_range(0, 3000)));
      write_reg(pidspd_pkg::REG_DERIV, 16'($urandom()));
      write_reg(pidspd_pkg::REG_REVERSE, 16'($urandom_range(0, 1)));
      write_reg(pidspd_pkg::REG_DUTYTOP, 16'($urandom_range(1, 65535)));
      write_reg(pidspd_pkg::REG_UPPER, 16'($urandom_range(0, 32767)));
      write_reg(pidspd_pkg::REG_LOWER, 16'(-$signed($urandom_range(0, 32768))));
      done_base = n_control + n_calib;
      random_phase(380);
      wait_idle();
    end

    $display("Covered %0d control and %0d calibration ticks, %0d results checked.",
             n_control, n_calib, n_results);
    if (n_errors == 0 && duty_expect.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pidspd_pkg.sv
rtl/core/pidspd_mul.sv
rtl/core/pid_speed_loop_with_feedforward_unit.sv
bench/pid_speed_loop_with_feedforward_unit_test.sv
